// ===== src/bfla_pkg.sv =====
// Shared types, constants and codes for the block refill free list allocator.
package bfla_pkg;

    localparam int SLOT_W     = 12;
    localparam int SLOT_SPACE = 4096;
    localparam int LINK_W     = SLOT_W + 1;
    localparam int SPACE_W    = SLOT_W + 1;

    localparam int SLOTS_PER_BLOCK_DEF = 512;
    localparam int POOL_BLOCKS_DEF     = 8;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] STATUS_ALLOC     = 2'd0;
    localparam logic [1:0] STATUS_FREED     = 2'd1;
    localparam logic [1:0] STATUS_NULL      = 2'd2;
    localparam logic [1:0] STATUS_EXHAUSTED = 2'd3;

    typedef struct packed {
        logic              operation;
        logic [SLOT_W-1:0] slot_to_free;
        logic              null_pointer;
    } in_item_t;

    typedef struct packed {
        logic [SLOT_W-1:0] granted_slot;
        logic [1:0]        status;
    } out_item_t;

    // One write into the link memory; bit SLOT_W of data is the link valid bit.
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic [LINK_W-1:0] data;
    } link_wr_t;

endpackage

// ===== src/block_refill_free_list_allocator.sv =====
// Top level of the block refill free list allocator.
//
// This block hands out and takes back fixed-size slots (indexes 0 to 4095) through a
// linked free list kept in a 4096-entry link memory. An allocate item pops the head of
// the list; when the list is empty the block carves the next whole block of
// SLOTS_PER_BLOCK slots from the pool, grants its first slot, chains the rest in
// ascending order and makes the second slot the new head. When the pool is used up the
// result reports exhaustion and nothing changes. A free item pushes its slot onto the
// list, and a free of a null pointer is reported and ignored. The block works on one
// item at a time: every item has an accept cycle, in which the link of the current head
// is read, and an execute step, except that an allocate that refills the list first waits
// while the carver writes one link per cycle through the single write port of the link
// memory. A finished result waits in the output register; the next item is accepted
// meanwhile and only its execute step waits if the output register is still full. The
// link memory needs no clearing pass after reset, since only links that were written are
// ever read.
module block_refill_free_list_allocator #(
    parameter int SLOTS_PER_BLOCK = bfla_pkg::SLOTS_PER_BLOCK_DEF,
    parameter int POOL_BLOCKS     = bfla_pkg::POOL_BLOCKS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bfla_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output bfla_pkg::out_item_t m_item
);
    import bfla_pkg::*;

    // Only blocks that lie wholly inside the slot space can be carved.
    localparam int FIT_BLOCKS = SLOT_SPACE / SLOTS_PER_BLOCK;
    localparam int MAX_BLOCKS = (POOL_BLOCKS < FIT_BLOCKS) ? POOL_BLOCKS : FIT_BLOCKS;
    localparam int BLK_W      = $clog2(MAX_BLOCKS + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_EXEC   = 2'd1;
    localparam logic [1:0] ST_CARVE  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]         state_reg, state_next;
    in_item_t           item_reg, item_next;
    logic [SLOT_W-1:0]  head_reg, head_next;
    logic               present_reg, present_next;
    logic [BLK_W-1:0]   blocks_reg, blocks_next;
    logic [SPACE_W-1:0] base_reg, base_next;
    logic [SLOT_W-1:0]  grant_reg, grant_next;
    logic               m_valid_reg, m_valid_next;
    out_item_t          m_item_reg, m_item_next;

    logic               accept;
    logic               out_free;
    logic               available;
    logic               carve_start;
    logic               carve_done;
    link_wr_t           carve_wr;
    link_wr_t           free_wr;
    link_wr_t           ram_wr;
    logic [LINK_W-1:0]  rd_link;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign available = (blocks_reg < BLK_W'(MAX_BLOCKS));
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;

    // The link of the current head is read at the accept edge, so it is ready for the
    // execute cycle. Nothing writes the memory while the block is idle.
    bfla_ram #(
        .WIDTH (LINK_W),
        .DEPTH (SLOT_SPACE)
    ) u_link_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr.en),
        .wr_addr (ram_wr.addr),
        .wr_data (ram_wr.data),
        .rd_en   (accept),
        .rd_addr (head_reg),
        .rd_data (rd_link)
    );

    bfla_carver #(
        .SLOTS_PER_BLOCK (SLOTS_PER_BLOCK)
    ) u_carver (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (carve_start),
        .base    (base_reg),
        .wr      (carve_wr),
        .done    (carve_done)
    );

    // Free pushes and carve steps never overlap, so the write port is a plain merge.
    always_comb begin
        ram_wr = carve_wr.en ? carve_wr : free_wr;
    end

    always_comb begin
        state_next   = state_reg;
        item_next    = item_reg;
        head_next    = head_reg;
        present_next = present_reg;
        blocks_next  = blocks_reg;
        base_next    = base_reg;
        grant_next   = grant_reg;
        m_item_next  = m_item_reg;
        m_valid_next = m_valid_reg && !m_ready;
        carve_start  = 1'b0;
        free_wr.en   = 1'b0;
        free_wr.addr = item_reg.slot_to_free;
        free_wr.data = present_reg ? {1'b1, head_reg} : '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    item_next  = s_item;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (item_reg.operation == OP_ALLOC) begin
                    if (present_reg) begin
                        if (out_free) begin
                            m_item_next  = '{granted_slot: head_reg, status: STATUS_ALLOC};
                            m_valid_next = 1'b1;
                            present_next = rd_link[SLOT_W];
                            head_next    = rd_link[SLOT_W] ? rd_link[SLOT_W-1:0] : '0;
                            state_next   = ST_IDLE;
                        end
                    end else if (available) begin
                        // The list is empty: refill it from the pool first.
                        carve_start = 1'b1;
                        grant_next  = base_reg[SLOT_W-1:0];
                        state_next  = ST_CARVE;
                    end else if (out_free) begin
                        m_item_next  = '{granted_slot: '0, status: STATUS_EXHAUSTED};
                        m_valid_next = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end else if (item_reg.null_pointer) begin
                    if (out_free) begin
                        m_item_next  = '{granted_slot: '0, status: STATUS_NULL};
                        m_valid_next = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end else if (out_free) begin
                    // Push: the freed slot links to the old head and becomes the head.
                    free_wr.en   = 1'b1;
                    head_next    = item_reg.slot_to_free;
                    present_next = 1'b1;
                    m_item_next  = '{granted_slot: '0, status: STATUS_FREED};
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_CARVE: begin
                if (carve_done) begin
                    head_next    = grant_reg + SLOT_W'(1);
                    present_next = 1'b1;
                    blocks_next  = blocks_reg + BLK_W'(1);
                    base_next    = base_reg + SPACE_W'(SLOTS_PER_BLOCK);
                    state_next   = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_item_next  = '{granted_slot: grant_reg, status: STATUS_ALLOC};
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            present_reg <= 1'b0;
            blocks_reg  <= '0;
            base_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            present_reg <= present_next;
            blocks_reg  <= blocks_next;
            base_reg    <= base_next;
            m_valid_reg <= m_valid_next;
        end
        item_reg   <= item_next;
        grant_reg  <= grant_next;
        m_item_reg <= m_item_next;
    end

endmodule

// ===== src/bfla_ram.sv =====
// Generic single write port, single read port RAM with a registered read.
module bfla_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== src/bfla_carver.sv =====
// Block carver: walks one new block of slots and chains their links in order.
module bfla_carver #(
    parameter int SLOTS_PER_BLOCK = bfla_pkg::SLOTS_PER_BLOCK_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [bfla_pkg::SPACE_W-1:0] base,
    output bfla_pkg::link_wr_t       wr,
    output logic                     done
);
    import bfla_pkg::*;

    localparam logic [SPACE_W-1:0] SPAN = SPACE_W'(SLOTS_PER_BLOCK - 1);

    logic               busy_reg, busy_next;
    logic [SPACE_W-1:0] addr_reg, addr_next;
    logic [SPACE_W-1:0] last_reg, last_next;
    logic [SPACE_W-1:0] addr_inc;
    logic               at_last;

    // The single incrementer and compare are shared across every step of the walk.
    assign addr_inc = addr_reg + SPACE_W'(1);
    assign at_last  = (addr_reg == last_reg);

    always_comb begin
        wr.en   = busy_reg;
        wr.addr = addr_reg[SLOT_W-1:0];
        wr.data = at_last ? '0 : {1'b1, addr_inc[SLOT_W-1:0]};
        done    = busy_reg && at_last;

        busy_next = busy_reg;
        addr_next = addr_reg;
        last_next = last_reg;
        if (start) begin
            busy_next = 1'b1;
            addr_next = base + SPACE_W'(1);
            last_next = base + SPAN;
        end else if (busy_reg) begin
            addr_next = addr_inc;
            if (at_last) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        addr_reg <= addr_next;
        last_reg <= last_next;
    end

endmodule

// ===== src/bfla_checker.sv =====
// Port-level assertions for the allocator, bound to its top level.
module bfla_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input bfla_pkg::in_item_t  s_item,
    input logic                m_valid,
    input logic                m_ready,
    input bfla_pkg::out_item_t m_item
);
    import bfla_pkg::*;

    // A result that is not taken stays offered unchanged.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed or dropped while stalled");

    // Every item needs an execute cycle, so the block is busy right after an accept.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("block accepted items in consecutive cycles");

    // Only a successful allocate carries a slot index.
    a_zero_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_item.status != STATUS_ALLOC) |-> (m_item.granted_slot == '0))
        else $error("non-allocate result carries a slot index");

    // A free with an empty output stage is answered right after its execute cycle.
    a_free_answer: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_item.operation == OP_FREE)) ##1 !m_valid
        |=> m_valid && ((m_item.status == STATUS_FREED) || (m_item.status == STATUS_NULL)))
        else $error("free item not answered with a free status");

endmodule

bind block_refill_free_list_allocator bfla_checker u_bfla_checker (.*);
